### rtl/rth_pkg.sv
`default_nettype none
package rth_pkg;

  localparam int CHAN_W    = 8;
  localparam int HUE_W     = 9;
  localparam int QUO_W     = 8;
  localparam int NUM_W     = CHAN_W + QUO_W;
  localparam int NUM_CELLS = QUO_W;

  localparam logic [CHAN_W-1:0] HALF_SPAN  = 8'd127;
  localparam logic [CHAN_W:0]   FULL_SUM   = 9'd510;
  localparam logic [HUE_W-1:0]  GREEN_BASE = 9'd120;
  localparam logic [HUE_W-1:0]  BLUE_BASE  = 9'd240;
  localparam logic [HUE_W-1:0]  FULL_TURN  = 9'd360;

  typedef logic [1:0] sector_t;
  localparam sector_t SEC_RED   = 2'd0;
  localparam sector_t SEC_GREEN = 2'd1;
  localparam sector_t SEC_BLUE  = 2'd2;

  // one restoring division in flight: partial remainder, numerator/quotient
  // shift word, divisor
  typedef struct packed {
    logic [CHAN_W-1:0] rem;
    logic [QUO_W-1:0]  low;
    logic [CHAN_W-1:0] den;
  } div_t;

  typedef struct packed {
    div_t              sat;
    div_t              hue;
    logic [CHAN_W-1:0] light;
    sector_t           sector;
    logic              neg;
    logic              chroma;
  } cell_t;

endpackage
`default_nettype wire

### rtl/rth_pix_if.sv
`default_nettype none
interface rth_pix_if import rth_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red_in;
  logic [CHAN_W-1:0] green_in;
  logic [CHAN_W-1:0] blue_in;

  modport source (output valid, output red_in, output green_in, output blue_in,
                  input ready);
  modport sink (input valid, input red_in, input green_in, input blue_in,
                output ready);
endinterface
`default_nettype wire

### rtl/rth_hsl_if.sv
`default_nettype none
interface rth_hsl_if import rth_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [HUE_W-1:0]  hue_deg;
  logic [CHAN_W-1:0] sat_level;
  logic [CHAN_W-1:0] light_level;

  modport source (output valid, output hue_deg, output sat_level,
                  output light_level, input ready);
  modport sink (input valid, input hue_deg, input sat_level, input light_level,
                output ready);
endinterface
`default_nettype wire

### rtl/rgb_to_hsl.sv
// RGB to HSL pixel converter.
// in_pix carries one 8-bit RGB pixel per word (valid/ready); out_hsl
// carries hue in degrees (0..359), saturation and lightness (0..255).
// A word moves on a rising clk edge with valid and ready both high.
// One pixel is accepted per cycle while in_pix.ready is high; each result
// is valid at the end of ten register stages: the accepting edge loads
// max/min, lightness and the numerators, eight cells that each retire one
// quotient bit of the saturation and hue divisions follow, and one output
// register forms hue.
// Every stage has its own valid bit and takes a new word when it is
// empty or its successor advances, so a stall at out_hsl fills the empty
// stages first; in_pix.ready drops only once all ten stages are full.
// A held result stays stable until taken.
// Reset (rst_n low, synchronous) empties all stages; no pixel is lost
// or repeated across a stall.
`default_nettype none
module rgb_to_hsl import rth_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  rth_pix_if.sink   in_pix,
  rth_hsl_if.source out_hsl
);

  cell_t              word [0:NUM_CELLS];
  logic [NUM_CELLS:0] vld;
  logic [NUM_CELLS:0] rdy;

  rth_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .pix      (in_pix),
    .dn_word  (word[0]),
    .dn_valid (vld[0]),
    .dn_ready (rdy[0])
  );

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    rth_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_word  (word[i]),
      .up_valid (vld[i]),
      .up_ready (rdy[i]),
      .dn_word  (word[i+1]),
      .dn_valid (vld[i+1]),
      .dn_ready (rdy[i+1])
    );
  end

  rth_fin u_fin (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_word  (word[NUM_CELLS]),
    .up_valid (vld[NUM_CELLS]),
    .up_ready (rdy[NUM_CELLS]),
    .hsl      (out_hsl)
  );

  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_hsl.valid |-> (out_hsl.hue_deg < FULL_TURN))
    else $error("hue out of range");

  a_gray_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_hsl.valid && (out_hsl.sat_level == '0)) |-> (out_hsl.hue_deg == '0))
    else $error("zero saturation with nonzero hue");

  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    (vld[0] && word[0].chroma) |->
      ((word[0].sat.rem < word[0].sat.den) && (word[0].hue.rem < word[0].hue.den)))
    else $error("quotient would overflow the cell chain");

endmodule
`default_nettype wire

### rtl/rth_prep.sv
`default_nettype none
module rth_prep import rth_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  rth_pix_if.sink   pix,
  output cell_t     dn_word,
  output logic      dn_valid,
  input  wire logic dn_ready
);

  logic              valid_r;
  cell_t             word_r;
  cell_t             word_nxt;
  logic              adv;
  logic [CHAN_W-1:0] mx;
  logic [CHAN_W-1:0] mn;
  logic [CHAN_W:0]   sum;
  logic [CHAN_W:0]   flip;
  logic [CHAN_W-1:0] light;
  logic [CHAN_W-1:0] diff;
  logic [CHAN_W-1:0] ha;
  logic [CHAN_W-1:0] hb;
  logic [CHAN_W-1:0] mag;
  logic [NUM_W-1:0]  sat_num;
  logic [NUM_W-1:0]  hue_num;
  logic              neg;
  sector_t           sector;

  assign adv       = !valid_r || dn_ready;
  assign pix.ready = adv;
  assign dn_valid  = valid_r;
  assign dn_word   = word_r;

  always_comb begin
    mx = pix.red_in;
    if (pix.green_in > mx) mx = pix.green_in;
    if (pix.blue_in > mx) mx = pix.blue_in;
    mn = pix.red_in;
    if (pix.green_in < mn) mn = pix.green_in;
    if (pix.blue_in < mn) mn = pix.blue_in;

    sum   = {1'b0, mx} + {1'b0, mn};
    flip  = FULL_SUM - sum;
    light = sum[CHAN_W:1];
    diff  = mx - mn;

    if (mx == pix.red_in) begin
      sector = SEC_RED;
      ha     = pix.green_in;
      hb     = pix.blue_in;
    end else if (mx == pix.green_in) begin
      sector = SEC_GREEN;
      ha     = pix.blue_in;
      hb     = pix.red_in;
    end else begin
      sector = SEC_BLUE;
      ha     = pix.red_in;
      hb     = pix.green_in;
    end
    neg = ha < hb;
    mag = neg ? (hb - ha) : (ha - hb);

    // diff*255 and mag*60 by shift and subtract
    sat_num = {diff, {QUO_W{1'b0}}} - {{QUO_W{1'b0}}, diff};
    hue_num = {2'b00, mag, 6'b000000} - {6'b000000, mag, 2'b00};

    word_nxt.sat.rem = sat_num[NUM_W-1:QUO_W];
    word_nxt.sat.low = sat_num[QUO_W-1:0];
    word_nxt.sat.den = (light > HALF_SPAN) ? flip[CHAN_W-1:0] : sum[CHAN_W-1:0];
    word_nxt.hue.rem = hue_num[NUM_W-1:QUO_W];
    word_nxt.hue.low = hue_num[QUO_W-1:0];
    word_nxt.hue.den = diff;
    word_nxt.light   = light;
    word_nxt.sector  = sector;
    word_nxt.neg     = neg;
    word_nxt.chroma  = (mx != mn);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= pix.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && pix.valid) begin
      word_r <= word_nxt;
    end
  end

endmodule
`default_nettype wire

### rtl/rth_cell.sv
`default_nettype none
module rth_cell import rth_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire cell_t up_word,
  input  wire logic  up_valid,
  output logic       up_ready,
  output cell_t      dn_word,
  output logic       dn_valid,
  input  wire logic  dn_ready
);

  logic  valid_r;
  cell_t word_r;
  cell_t word_nxt;

  // shift in one numerator bit, subtract the divisor when it fits
  function automatic div_t div_step(input div_t d);
    logic [CHAN_W:0] t;
    logic            fit;
    div_t            o;
    t       = {d.rem, d.low[QUO_W-1]};
    fit     = (t >= {1'b0, d.den});
    o.den   = d.den;
    o.rem   = fit ? (t[CHAN_W-1:0] - d.den) : t[CHAN_W-1:0];
    o.low   = {d.low[QUO_W-2:0], fit};
    return o;
  endfunction

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_word  = word_r;

  always_comb begin
    word_nxt     = up_word;
    word_nxt.sat = div_step(up_word.sat);
    word_nxt.hue = div_step(up_word.hue);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      word_r <= word_nxt;
    end
  end

endmodule
`default_nettype wire

### rtl/rth_fin.sv
`default_nettype none
module rth_fin import rth_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire cell_t up_word,
  input  wire logic  up_valid,
  output logic       up_ready,
  rth_hsl_if.source  hsl
);

  logic              valid_r;
  logic [HUE_W-1:0]  hue_r;
  logic [CHAN_W-1:0] sat_r;
  logic [CHAN_W-1:0] light_r;
  logic [HUE_W-1:0]  hue_nxt;
  logic [CHAN_W-1:0] sat_nxt;
  logic [HUE_W-1:0]  q;

  assign up_ready        = !valid_r || hsl.ready;
  assign hsl.valid       = valid_r;
  assign hsl.hue_deg     = hue_r;
  assign hsl.sat_level   = sat_r;
  assign hsl.light_level = light_r;

  always_comb begin
    q = {1'b0, up_word.hue.low};
    case (up_word.sector)
      SEC_RED: begin
        if (up_word.neg) begin
          hue_nxt = FULL_TURN - q;
          if (hue_nxt == FULL_TURN) hue_nxt = '0;
        end else begin
          hue_nxt = q;
        end
      end
      SEC_GREEN: hue_nxt = up_word.neg ? (GREEN_BASE - q) : (GREEN_BASE + q);
      SEC_BLUE:  hue_nxt = up_word.neg ? (BLUE_BASE - q) : (BLUE_BASE + q);
      default:   hue_nxt = '0;
    endcase
    sat_nxt = up_word.sat.low;
    if (!up_word.chroma) begin
      hue_nxt = '0;
      sat_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      hue_r   <= hue_nxt;
      sat_r   <= sat_nxt;
      light_r <= up_word.light;
    end
  end

endmodule
`default_nettype wire
